### rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared types and fixed field widths for the sliding window rate meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

  // Fixed field widths of the stream items and the register
  localparam int unsigned AMOUNT_W    = 32;
  localparam int unsigned RATE_W      = 56;
  localparam int unsigned USED_W      = 5;
  localparam int unsigned WLEN_W      = 5;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned OUT_TDATA_W = 64;

  // Reset value of the window length register
  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd16;

  // Depth of the tick queue between front and back
  localparam int unsigned TICK_QUEUE_DEPTH = 2;

  // Item kinds carried in tuser
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } back_state_e;

endpackage

### rtl/swrm_ram.sv
// ----------------------------------------------------------------------------
// swrm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swrm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/swrm_fifo.sv
// ----------------------------------------------------------------------------
// swrm_fifo
// Short register queue that carries closed interval totals from front to back.
// ----------------------------------------------------------------------------
module swrm_fifo #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/swrm_front.sv
// ----------------------------------------------------------------------------
// swrm_front
// Input stage: accumulates arrival amounts and hands closed totals to the queue.
// ----------------------------------------------------------------------------
module swrm_front #(
  parameter int unsigned TOTAL_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [swrm_pkg::AMOUNT_W-1:0] s_axis_tdata,   // [31:0] amount
  input  logic                          s_axis_tuser,   // [0] mode
  input  logic                          queue_full_i,
  output logic                          push_o,
  output logic [TOTAL_BITS-1:0]         push_total_o
);

  import swrm_pkg::*;

  localparam int unsigned AW = ((TOTAL_BITS > AMOUNT_W) ? TOTAL_BITS : AMOUNT_W) + 1;

  logic [TOTAL_BITS-1:0] pending_q, pending_d;
  logic [AW-1:0]         wide_sum;
  logic                  saturate;
  logic                  accept;

  assign s_axis_tready = !queue_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Saturating add of the arrival amount
  assign wide_sum = AW'(pending_q) + AW'(s_axis_tdata);
  assign saturate = |wide_sum[AW-1:TOTAL_BITS];

  // Classify the item: arrivals accumulate, ticks close the interval
  always_comb begin
    pending_d = pending_q;
    push_o    = 1'b0;
    if (accept) begin
      if (s_axis_tuser == MODE_TICK) begin
        push_o    = 1'b1;
        pending_d = '0;
      end else begin
        pending_d = saturate ? '1 : wide_sum[TOTAL_BITS-1:0];
      end
    end
  end

  assign push_total_o = pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

### rtl/swrm_back.sv
// ----------------------------------------------------------------------------
// swrm_back
// Tick engine: updates the interval ring and window sum, then divides the sum
// by the fill count bit-serially and loads the result register.
// ----------------------------------------------------------------------------
module swrm_back #(
  parameter int unsigned WINDOW_MAX = 16,
  parameter int unsigned TOTAL_BITS = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swrm_pkg::WLEN_W-1:0]         cfg_wdata_i,
  input  logic                                queue_empty_i,
  input  logic [TOTAL_BITS-1:0]               queue_data_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [swrm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [55:0] average_rate,
                                                             // [60:56] intervals_used
);

  import swrm_pkg::*;

  localparam int unsigned PW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW  = TOTAL_BITS + $clog2(WINDOW_MAX);
  localparam int unsigned QW  = SW + FRAC_BITS;
  localparam int unsigned NW  = $clog2(QW + 1);

  back_state_e state_q, state_d;

  logic [WLEN_W-1:0]     wlen_q;
  logic [WINDOW_MAX-1:0] slot_valid_q, slot_valid_d;
  logic [SW-1:0]         sum_q, sum_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [PW-1:0]         slot_q;
  logic [TOTAL_BITS-1:0] total_q;
  logic [QW-1:0]         dvd_q, dvd_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic [NW-1:0]         cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [RATE_W-1:0]     rate_q;
  logic [USED_W-1:0]     used_q;

  logic [CW-1:0]         len;
  logic [PW-1:0]         slot_sel;
  logic [CW-1:0]         pos_next;
  logic [CW-1:0]         fill_new;
  logic [TOTAL_BITS-1:0] ram_rdata;
  logic [TOTAL_BITS-1:0] old_total;
  logic [SW-1:0]         sum_new;
  logic [CW:0]           rem_ext;
  logic                  rem_ge;
  logic [QW+RATE_W-1:0]  quot_ext;
  logic [CW+USED_W-1:0]  fill_ext;

  logic ram_re, ram_we, out_load, load_div, div_step;

  // Effective window length: zero acts as one, large values clamp
  always_comb begin
    if (wlen_q == '0) begin
      len = CW'(1);
    end else if (32'(wlen_q) > WINDOW_MAX) begin
      len = CW'(WINDOW_MAX);
    end else begin
      len = CW'(wlen_q);
    end
  end

  assign slot_sel  = (CW'(pos_q) >= len) ? '0 : pos_q;
  assign pos_next  = CW'(slot_q) + 1'b1;
  assign fill_new  = (fill_q < len) ? fill_q + 1'b1 : len;
  assign old_total = slot_valid_q[slot_q] ? ram_rdata : '0;
  assign sum_new   = sum_q - SW'(old_total) + SW'(total_q);

  // One restoring division step
  assign rem_ext = {rem_q, dvd_q[QW-1]};
  assign rem_ge  = (rem_ext >= {1'b0, fill_q});

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!queue_empty_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (cnt_q == NW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o    = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    load_div = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop_o  = !queue_empty_i;
        ram_re = !queue_empty_i;
      end
      ST_UPDATE: begin
        ram_we   = 1'b1;
        load_div = 1'b1;
      end
      ST_DIVIDE: begin
        div_step = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // Window state and divider datapath
  always_comb begin
    slot_valid_d = slot_valid_q;
    sum_d        = sum_q;
    pos_d        = pos_q;
    fill_d       = fill_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    if (cfg_we_i) begin
      slot_valid_d = '0;
      sum_d        = '0;
      pos_d        = '0;
      fill_d       = '0;
    end else if (load_div) begin
      slot_valid_d[slot_q] = 1'b1;
      sum_d                = sum_new;
      pos_d                = (pos_next >= len) ? '0 : PW'(pos_next);
      fill_d               = fill_new;
      dvd_d                = {sum_new, {FRAC_BITS{1'b0}}};
      rem_d                = '0;
      cnt_d                = NW'(QW);
    end else if (div_step) begin
      dvd_d = {dvd_q[QW-2:0], rem_ge};
      rem_d = rem_ge ? CW'(rem_ext - {1'b0, fill_q}) : rem_ext[CW-1:0];
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wlen_q       <= WLEN_RESET;
      slot_valid_q <= '0;
      sum_q        <= '0;
      pos_q        <= '0;
      fill_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_valid_q <= slot_valid_d;
      sum_q        <= sum_d;
      pos_q        <= pos_d;
      fill_q       <= fill_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
    end
  end

  // Truncate quotient and fill count to the result field widths
  assign quot_ext = {{RATE_W{1'b0}}, dvd_q};
  assign fill_ext = {{USED_W{1'b0}}, fill_q};

  // Payload registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (pop_o) begin
      slot_q  <= slot_sel;
      total_q <= queue_data_i;
    end
    if (out_load) begin
      rate_q <= quot_ext[RATE_W-1:0];
      used_q <= fill_ext[USED_W-1:0];
    end
  end

  swrm_ram #(
    .WIDTH (TOTAL_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (total_q),
    .re_i    (ram_re),
    .raddr_i (slot_sel),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - RATE_W - USED_W){1'b0}}, used_q, rate_q};

endmodule

### rtl/sliding_window_rate_meter.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_meter
// Throughput meter averaging per-interval byte totals over a sliding window.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (low bit up)                          Kind
//  s_axis    in   tdata: amount[31:0]; tuser: mode[0]           stream
//  m_axis    out  tdata: average_rate[55:0], intervals_used     stream
//                 [60:56], zero [63:61]
//  cfg       in   cfg_wdata_i: window_length[4:0]               write only
//
//  Arrival items are taken one per cycle while the queue is not full and add
//  into the pending total. A tick is taken and queued (two deep); the back end
//  handles one tick at a time, dividing the window sum by the fill count with a
//  one-bit-per-cycle divider; s_axis stalls only when the queue fills.
//  Reset clears the ring through per-slot valid bits, no clearing pass.
//  A result waits in the output register while the back end starts the next tick.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter #(
  parameter int unsigned WINDOW_MAX = 16,
  parameter int unsigned TOTAL_BITS = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [swrm_pkg::AMOUNT_W-1:0]    s_axis_tdata,   // [31:0] amount
  input  logic                             s_axis_tuser,   // [0] mode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [swrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [55:0] average_rate,
                                                           // [60:56] intervals_used
  input  logic                             cfg_we_i,
  input  logic [swrm_pkg::WLEN_W-1:0]      cfg_wdata_i
);

  import swrm_pkg::*;

  logic                  push, queue_full, queue_empty, pop;
  logic [TOTAL_BITS-1:0] push_total, pop_total;

  // Accept and classify items
  swrm_front #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_total_o  (push_total)
  );

  // Hold closed interval totals
  swrm_fifo #(
    .WIDTH (TOTAL_BITS),
    .DEPTH (TICK_QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_total),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  (pop_total),
    .empty_o     (queue_empty)
  );

  // Update the window and compute the average
  swrm_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .queue_empty_i (queue_empty),
    .queue_data_i  (pop_total),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
